>>> hw/rtl/bitmap_first_free_allocator_macros.svh
// Assertion shorthands used by the checker file.
`ifndef BITMAP_FIRST_FREE_ALLOCATOR_MACROS_SVH
`define BITMAP_FIRST_FREE_ALLOCATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BFFA_CHECK_NOW(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("bffa same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define BFFA_CHECK_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("bffa next-cycle check failed");

`endif

>>> hw/rtl/bffa_pkg.sv
package bffa_pkg;

  localparam int MAP_BYTES = 1024;
  localparam int ROW_BYTES = 32;
  localparam int ROWS      = MAP_BYTES / ROW_BYTES;
  localparam int ROW_BITS  = ROW_BYTES * 8;
  localparam int LANE_W    = $clog2(ROW_BYTES);
  localparam int ROW_W     = $clog2(ROWS);
  localparam int BYTE_AW   = $clog2(MAP_BYTES);
  localparam int MEM_AW    = ROW_W + 1;
  localparam int MEM_ROWS  = 2 * ROWS;

  // Field widths fixed by the interface.
  localparam int CNT_W  = 11;
  localparam int NUM_W  = 14;
  localparam int IDX_W  = 10;

  localparam logic [CNT_W-1:0] CFG_RESET = 11'd1024;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = 1;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_LOAD  = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // One classified request as it travels from the front end to the back end.
  typedef struct packed {
    logic [1:0]         mode;
    logic               map_sel;
    logic               err;
    logic [BYTE_AW-1:0] byte_addr;
    logic [2:0]         bit_sel;
    logic [7:0]         value;
  } req_t;

endpackage

>>> hw/rtl/bffa_front.sv
module bffa_front (
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  mode,
  input  logic                        map_select,
  input  logic [bffa_pkg::NUM_W-1:0]  item_number,
  input  logic [bffa_pkg::IDX_W-1:0]  byte_index,
  input  logic [7:0]                  byte_value,
  input  logic [bffa_pkg::CNT_W-1:0]  n_active,
  input  logic                        fifo_full,
  output logic                        push,
  output bffa_pkg::req_t              req
);

  logic [bffa_pkg::NUM_W:0]   num_limit;
  logic [bffa_pkg::NUM_W-1:0] k;
  logic                       err_free;
  logic                       err_idx;

  assign in_ready = !fifo_full;
  assign push     = in_valid && !fifo_full;

  // A number is legal when it is nonzero and at most eight times the bytes in use.
  assign num_limit = (bffa_pkg::NUM_W + 1)'({n_active, 3'b000});
  assign err_free  = (item_number == '0) ||
                     ((bffa_pkg::NUM_W + 1)'(item_number) > num_limit);
  assign err_idx   = bffa_pkg::CNT_W'(byte_index) >= n_active;
  assign k         = item_number - bffa_pkg::NUM_W'(1);

  always_comb begin
    req.mode    = mode;
    req.map_sel = map_select;
    req.value   = byte_value;
    req.bit_sel = k[2:0];
    if (mode == bffa_pkg::MODE_FREE) begin
      req.byte_addr = k[bffa_pkg::BYTE_AW+2:3];
    end else begin
      req.byte_addr = bffa_pkg::BYTE_AW'(byte_index);
    end
    case (mode)
      bffa_pkg::MODE_ALLOC: req.err = 1'b0;
      bffa_pkg::MODE_FREE:  req.err = err_free;
      default:              req.err = err_idx;
    endcase
  end

endmodule

>>> hw/rtl/bffa_fifo.sv
module bffa_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bffa_pkg::req_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output bffa_pkg::req_t pop_data
);

  bffa_pkg::req_t                 entries [bffa_pkg::FIFO_DEPTH];
  logic [bffa_pkg::FIFO_AW-1:0]   wr_ptr;
  logic [bffa_pkg::FIFO_AW-1:0]   rd_ptr;
  logic [bffa_pkg::FIFO_AW:0]     count;

  assign full     = count == (bffa_pkg::FIFO_AW + 1)'(bffa_pkg::FIFO_DEPTH);
  assign valid    = count != '0;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + bffa_pkg::FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + bffa_pkg::FIFO_AW'(1);
      end
      if (push && !pop) begin
        count <= count + (bffa_pkg::FIFO_AW + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (bffa_pkg::FIFO_AW + 1)'(1);
      end
    end
  end

endmodule

>>> hw/rtl/bffa_back.sv
module bffa_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  input  bffa_pkg::req_t              req,
  output logic                        req_pop,
  input  logic [bffa_pkg::CNT_W-1:0]  n_active,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bffa_pkg::NUM_W-1:0]  result_number,
  output logic [7:0]                  read_byte,
  output logic [1:0]                  status
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_SET  = 3'd2;
  localparam logic [2:0] S_MOD  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  // Both maps share one memory; the top address bit picks the map.
  logic [bffa_pkg::ROW_BITS-1:0] mem [bffa_pkg::MEM_ROWS];
  logic [bffa_pkg::MEM_ROWS-1:0] row_valid;
  logic [bffa_pkg::ROW_BITS-1:0] mem_q;
  logic                          mem_q_vld;
  logic                          mem_re;
  logic                          mem_we;
  logic [bffa_pkg::MEM_AW-1:0]   mem_raddr;
  logic [bffa_pkg::MEM_AW-1:0]   mem_waddr;
  logic [bffa_pkg::ROW_BITS-1:0] mem_wdata;

  logic [2:0]                    state;
  bffa_pkg::req_t                cur;
  logic [bffa_pkg::ROW_W-1:0]    scan_row;
  logic [bffa_pkg::ROW_W-1:0]    eval_row;
  logic                          data_vld;
  logic                          issue_done;
  logic [bffa_pkg::LANE_W-1:0]   hit_lane;
  logic [1:0]                    done_status;

  logic [bffa_pkg::CNT_W-1:0]    nm1;
  logic [bffa_pkg::ROW_W-1:0]    last_row;
  logic [bffa_pkg::LANE_W-1:0]   last_lane;
  logic [bffa_pkg::ROW_BITS-1:0] word;
  logic [bffa_pkg::ROW_BYTES-1:0] lane_free;
  logic                          hit;
  logic [bffa_pkg::LANE_W-1:0]   hit_enc;
  logic [bffa_pkg::LANE_W-1:0]   sel_lane;
  logic [bffa_pkg::ROW_W-1:0]    sel_row;
  logic [7:0]                    sel_byte;
  logic [2:0]                    zero_bit;
  logic [2:0]                    sel_bit;
  logic [bffa_pkg::ROW_BITS-1:0] bit_mask;
  logic [bffa_pkg::ROW_BITS-1:0] lane_mask;
  logic [bffa_pkg::ROW_BITS-1:0] lane_value;
  logic                          can_out;
  logic                          out_load;
  logic [bffa_pkg::NUM_W-1:0]    res_num;
  logic [7:0]                    res_byte;
  logic [1:0]                    res_status;

  assign nm1       = n_active - bffa_pkg::CNT_W'(1);
  assign last_row  = nm1[bffa_pkg::BYTE_AW-1:bffa_pkg::LANE_W];
  assign last_lane = nm1[bffa_pkg::LANE_W-1:0];
  // A row never written reads as all zero.
  assign word      = mem_q_vld ? mem_q : '0;
  assign can_out   = !out_valid || out_ready;

  always_comb begin
    lane_free = '0;
    hit_enc   = '0;
    for (int b = 0; b < bffa_pkg::ROW_BYTES; b++) begin
      lane_free[b] = ((eval_row != last_row) || (bffa_pkg::LANE_W'(b) <= last_lane)) &&
                     (word[b*8 +: 8] != 8'hff);
    end
    for (int b = bffa_pkg::ROW_BYTES - 1; b >= 0; b--) begin
      if (lane_free[b]) begin
        hit_enc = bffa_pkg::LANE_W'(b);
      end
    end
  end

  assign hit = |lane_free;

  assign sel_lane = (state == S_SET) ? hit_lane :
                    cur.byte_addr[bffa_pkg::LANE_W-1:0];
  assign sel_row  = (state == S_SET) ? eval_row :
                    cur.byte_addr[bffa_pkg::BYTE_AW-1:bffa_pkg::LANE_W];
  assign sel_byte = word[{sel_lane, 3'b000} +: 8];

  always_comb begin
    zero_bit = '0;
    for (int j = 7; j >= 0; j--) begin
      if (!sel_byte[j]) begin
        zero_bit = 3'(j);
      end
    end
  end

  assign sel_bit    = (state == S_SET) ? zero_bit : cur.bit_sel;
  assign bit_mask   = bffa_pkg::ROW_BITS'(1) << {sel_lane, sel_bit};
  assign lane_mask  = bffa_pkg::ROW_BITS'(8'hff) << {sel_lane, 3'b000};
  assign lane_value = bffa_pkg::ROW_BITS'(cur.value) << {sel_lane, 3'b000};
  assign mem_waddr  = {cur.map_sel, sel_row};

  always_comb begin
    req_pop    = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = {cur.map_sel, scan_row};
    mem_we     = 1'b0;
    mem_wdata  = word;
    out_load   = 1'b0;
    res_num    = '0;
    res_byte   = '0;
    res_status = bffa_pkg::ST_DONE;
    case (state)
      S_IDLE: begin
        req_pop = req_valid;
        if (req_valid && !req.err && (req.mode != bffa_pkg::MODE_ALLOC)) begin
          mem_re    = 1'b1;
          mem_raddr = {req.map_sel,
                       req.byte_addr[bffa_pkg::BYTE_AW-1:bffa_pkg::LANE_W]};
        end
      end
      S_SCAN: begin
        // Hold the read data once a row with a free lane has turned up or the last row has been issued.
        if (!(data_vld && hit) && !(data_vld && (eval_row == last_row)) && !issue_done) begin
          mem_re = 1'b1;
        end
      end
      S_SET: begin
        if (can_out) begin
          mem_we    = 1'b1;
          mem_wdata = word | bit_mask;
          out_load  = 1'b1;
          res_num   = bffa_pkg::NUM_W'({eval_row, hit_lane, zero_bit}) +
                      bffa_pkg::NUM_W'(1);
        end
      end
      S_MOD: begin
        if (can_out) begin
          out_load = 1'b1;
          case (cur.mode)
            bffa_pkg::MODE_FREE: begin
              mem_we    = 1'b1;
              mem_wdata = word & ~bit_mask;
            end
            bffa_pkg::MODE_LOAD: begin
              mem_we    = 1'b1;
              mem_wdata = (word & ~lane_mask) | lane_value;
            end
            bffa_pkg::MODE_READ: begin
              res_byte = sel_byte;
            end
            default: begin
            end
          endcase
        end
      end
      S_DONE: begin
        if (can_out) begin
          out_load   = 1'b1;
          res_status = done_status;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q     <= mem[mem_raddr];
      mem_q_vld <= row_valid[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (mem_we) begin
      row_valid[mem_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_number <= res_num;
      read_byte     <= res_byte;
      status        <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      data_vld   <= 1'b0;
      issue_done <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur <= req;
            if (req.err) begin
              done_status <= bffa_pkg::ST_RANGE;
              state       <= S_DONE;
            end else if (req.mode == bffa_pkg::MODE_ALLOC) begin
              if (n_active == '0) begin
                done_status <= bffa_pkg::ST_FULL;
                state       <= S_DONE;
              end else begin
                scan_row   <= '0;
                issue_done <= 1'b0;
                data_vld   <= 1'b0;
                state      <= S_SCAN;
              end
            end else begin
              state <= S_MOD;
            end
          end
        end
        S_SCAN: begin
          if (data_vld && hit) begin
            hit_lane <= hit_enc;
            state    <= S_SET;
          end else if (data_vld && (eval_row == last_row)) begin
            done_status <= bffa_pkg::ST_FULL;
            state       <= S_DONE;
          end else if (!issue_done) begin
            eval_row <= scan_row;
            data_vld <= 1'b1;
            if (scan_row == last_row) begin
              issue_done <= 1'b1;
            end else begin
              scan_row <= scan_row + bffa_pkg::ROW_W'(1);
            end
          end else begin
            data_vld <= 1'b0;
          end
        end
        S_SET, S_MOD, S_DONE: begin
          if (can_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/bitmap_first_free_allocator.sv
// Two-map first-fit allocator (block map and inode map, 1024 bytes each, one bit per
// 1-based item). Requests enter a two-word queue and are carried out one at a time;
// an accepted word is registered into the queue and waits there for the back end.
// Free, load and read go from the queue head through an idle state, which issues the
// memory read, and a modify state into the result register; a request that fails its
// range check, or an allocate that finds no byte in use, goes through a done state
// instead. Allocate reads the map memory one 32-byte row per cycle from its single
// read port, up to the last row in use, stopping once a free bit turns up. A result
// word that is not taken holds the back end until it is. The map memory needs no
// clearing pass after reset: each row has a valid bit, and an unwritten row reads as
// all zero. Write bytes_in_use only while no word is in flight.
module bitmap_first_free_allocator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [bffa_pkg::CNT_W-1:0]  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  mode,
  input  logic                        map_select,
  input  logic [bffa_pkg::NUM_W-1:0]  item_number,
  input  logic [bffa_pkg::IDX_W-1:0]  byte_index,
  input  logic [7:0]                  byte_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bffa_pkg::NUM_W-1:0]  result_number,
  output logic [7:0]                  read_byte,
  output logic [1:0]                  status
);

  logic [bffa_pkg::CNT_W-1:0] bytes_in_use;
  logic [bffa_pkg::CNT_W-1:0] n_active;
  logic                       fifo_full;
  logic                       push;
  bffa_pkg::req_t             push_req;
  logic                       pop;
  logic                       head_valid;
  bffa_pkg::req_t             head_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_in_use <= bffa_pkg::CFG_RESET;
    end else if (cfg_we) begin
      bytes_in_use <= cfg_wdata;
    end
  end

  // Values above the map size count as the whole map.
  assign n_active = (bytes_in_use > bffa_pkg::CNT_W'(bffa_pkg::MAP_BYTES)) ?
                    bffa_pkg::CNT_W'(bffa_pkg::MAP_BYTES) : bytes_in_use;

  bffa_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .map_select  (map_select),
    .item_number (item_number),
    .byte_index  (byte_index),
    .byte_value  (byte_value),
    .n_active    (n_active),
    .fifo_full   (fifo_full),
    .push        (push),
    .req         (push_req)
  );

  bffa_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_req),
    .full      (fifo_full),
    .pop       (pop),
    .valid     (head_valid),
    .pop_data  (head_req)
  );

  bffa_back u_back (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (head_valid),
    .req           (head_req),
    .req_pop       (pop),
    .n_active      (n_active),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_number (result_number),
    .read_byte     (read_byte),
    .status        (status)
  );

endmodule

>>> hw/rtl/bffa_checker.sv
`include "bitmap_first_free_allocator_macros.svh"

module bffa_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [bffa_pkg::NUM_W-1:0]  result_number,
  input logic [7:0]                  read_byte,
  input logic [1:0]                  status
);

  // A stalled result word must hold.
  `BFFA_CHECK_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(result_number) && $stable(read_byte) && $stable(status))

  // Status never carries the unused code.
  `BFFA_CHECK_NOW(a_status_code, clk, rst, out_valid, (status == bffa_pkg::ST_DONE) || (status == bffa_pkg::ST_FULL) || (status == bffa_pkg::ST_RANGE))

  // A failed request returns no number and no byte.
  `BFFA_CHECK_NOW(a_fail_zero, clk, rst, out_valid && (status != bffa_pkg::ST_DONE), (result_number == '0) && (read_byte == '0))

  // An allocated number and a read byte never come in the same word.
  `BFFA_CHECK_NOW(a_num_xor_byte, clk, rst, out_valid && (result_number != '0), (read_byte == '0) && (status == bffa_pkg::ST_DONE))

endmodule

bind bitmap_first_free_allocator bffa_checker u_bffa_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .result_number (result_number),
  .read_byte     (read_byte),
  .status        (status)
);
